FILE: src/mt19937_generator_top_assert.svh
// ----------------------------------------------------------------------------
// MT19937 generator assertion macros
// Shorthand for clocked assertions on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MT19937_GENERATOR_TOP_ASSERT_SVH
`define MT19937_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define MTG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MTG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mtg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MT19937 generator package
// Constants, operation codes and the tempering function.
// ----------------------------------------------------------------------------
package mtg_pkg;

	localparam int STATE_WORDS = 624;
	localparam int SHIFT_M     = 397;

	localparam logic [31:0] MATRIX_A     = 32'h9908_B0DF;
	localparam logic [31:0] TOP_BIT_SEL  = 32'h8000_0000;
	localparam logic [31:0] LOW_BITS_SEL = 32'h7FFF_FFFF;
	localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
	localparam logic [31:0] INIT_MULT    = 32'd1812433253;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;
	localparam logic [31:0] FULL_RANGE   = 32'hFFFF_FFFF;

	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_SEED = 1'b1;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage
`default_nettype wire

FILE: src/mtg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MT19937 generator RAM
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mtg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: src/mt19937_generator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MT19937 generator
// 32-bit Mersenne Twister with 624 words of state held in two RAM copies.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with operation/seed_value/max_number; the transaction is taken
//   at a rising edge where start is high and busy is low.
//   A seed transaction (operation = 1) writes one state word per cycle with
//   the standard init recurrence, all 624 words, and returns nothing.
//   A draw transaction (operation = 0) twists one state word lazily, tempers
//   it and scales it to 0..max_number (max_number all ones returns the raw
//   tempered word). The result shows on value for exactly one cycle with
//   valid high; busy is low in that cycle, so the next draw can be taken
//   in it. For the three-read twist (current, next, far word) the current
//   word sits in a register and the other two are read from the two RAM
//   copies at the accepting edge (after an implicit seed, in a read state);
//   the twist/temper, multiply and final add states then follow in order.
//   A draw before any seed first seeds with 5489.
//   Reset marks the state unseeded and used up; the RAMs need no clearing.
//   The receiver cannot stall: valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
module mt19937_generator_top #(
	parameter int STATE_WORDS = mtg_pkg::STATE_WORDS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        operation,
	input  wire logic [31:0] seed_value,
	input  wire logic [31:0] max_number,
	output logic             valid,
	output logic [31:0]      value
);
	import mtg_pkg::*;

	localparam int AW    = $clog2(STATE_WORDS);
	localparam int IDX_W = $clog2(STATE_WORDS + 1);
	localparam int FAR_WRAP = STATE_WORDS - SHIFT_M;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEED = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_TW   = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic             seeded_q;
	logic             pend_q;
	logic [AW-1:0]    cnt_q;
	logic [31:0]      prev_q;
	logic [31:0]      cur_q;
	logic [AW-1:0]    k_q;
	logic [31:0]      max_q;
	logic [31:0]      temp_q;
	logic [63:0]      prod_q;
	logic             valid_q;
	logic [31:0]      value_q;

	logic             accept;
	logic             seed_start;
	logic [31:0]      seed_src;
	logic [31:0]      mix;
	logic [31:0]      seed_word;
	logic [AW-1:0]    k;
	logic [AW-1:0]    nx_addr;
	logic [AW-1:0]    fa_addr;
	logic [31:0]      nx_rd;
	logic [31:0]      fa_rd;
	logic [31:0]      ymix;
	logic [31:0]      twisted;
	logic [63:0]      scaled;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [31:0]      wdata;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign valid  = valid_q;
	assign value  = value_q;

	// Seed on an explicit seed, or on a draw before any seed.
	assign seed_start = accept && ((operation == OP_SEED) || !seeded_q);
	assign seed_src   = (operation == OP_SEED) ? seed_value : DEFAULT_SEED;

	// Init recurrence for word cnt_q from the previous word.
	assign mix       = prev_q ^ (prev_q >> 30);
	assign seed_word = 32'(INIT_MULT * mix) + 32'(cnt_q);

	// Word to twist; a used-up index wraps to word zero.
	assign k       = (idx_q >= IDX_W'(STATE_WORDS)) ? '0 : idx_q[AW-1:0];
	assign nx_addr = (k == AW'(STATE_WORDS - 1)) ? '0 : k + AW'(1);
	assign fa_addr = (k < AW'(FAR_WRAP)) ? k + AW'(SHIFT_M) : k - AW'(FAR_WRAP);

	// Twist: words below k are already new, words above k still old.
	assign ymix    = (cur_q & TOP_BIT_SEL) | (nx_rd & LOW_BITS_SEL);
	assign twisted = fa_rd ^ (ymix >> 1) ^ (ymix[0] ? MATRIX_A : '0);

	// y * (max + 1) = y * max + y; keep the upper half.
	assign scaled = prod_q + {32'd0, temp_q};

	// One write port shared by seeding and twisting, copied to both RAMs.
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = seed_src;
		if (seed_start) begin
			we = 1'b1;
		end else if (state_q == ST_SEED) begin
			we    = 1'b1;
			waddr = cnt_q;
			wdata = seed_word;
		end else if (state_q == ST_TW) begin
			we    = 1'b1;
			waddr = k_q;
			wdata = twisted;
		end
	end

	mtg_ram #(
		.WIDTH(32),
		.DEPTH(STATE_WORDS)
	) u_ram_nx (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(nx_addr),
		.rdata(nx_rd)
	);

	mtg_ram #(
		.WIDTH(32),
		.DEPTH(STATE_WORDS)
	) u_ram_fa (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(fa_addr),
		.rdata(fa_rd)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= IDX_W'(STATE_WORDS);
			seeded_q <= 1'b0;
			pend_q   <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (seed_start) begin
						pend_q  <= (operation == OP_DRAW);
						state_q <= ST_SEED;
					end else if (accept) begin
						state_q <= ST_TW;
					end
				end
				ST_SEED: begin
					if (cnt_q == AW'(STATE_WORDS - 1)) begin
						idx_q    <= IDX_W'(STATE_WORDS);
						seeded_q <= 1'b1;
						state_q  <= pend_q ? ST_RD : ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_TW;
				end
				ST_TW: begin
					idx_q   <= IDX_W'(k_q) + IDX_W'(1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (seed_start) begin
			prev_q <= seed_src;
			cur_q  <= seed_src;
			cnt_q  <= AW'(1);
		end else if (state_q == ST_SEED) begin
			prev_q <= seed_word;
			cnt_q  <= cnt_q + AW'(1);
		end
		if (accept) begin
			max_q <= max_number;
		end
		// Latch the word index along with the reads it drives.
		if ((accept && !seed_start) || (state_q == ST_RD)) begin
			k_q <= k;
		end
		if (state_q == ST_TW) begin
			// Next word's value, as read, becomes the current word of the next draw.
			cur_q  <= nx_rd;
			temp_q <= temper(twisted);
		end
		if (state_q == ST_MUL) begin
			prod_q <= 64'(temp_q) * 64'(max_q);
		end
		if (state_q == ST_FIN) begin
			value_q <= (max_q == FULL_RANGE) ? temp_q : scaled[63:32];
		end
	end

endmodule
`default_nettype wire

FILE: src/mtg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MT19937 generator port checker
// Watches the command and result ports of the top level over time.
// ----------------------------------------------------------------------------
`include "mt19937_generator_top_assert.svh"

module mtg_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic operation,
	input wire logic valid
);
	import mtg_pkg::*;

	logic seed_accept;

	assign seed_accept = start && !busy && (operation == OP_SEED);

	// A result only shows once the engine has gone idle.
	`MTG_ASSERT_NOW(a_valid_idle, valid, !busy, "result strobe while busy")
	// The strobe lasts one cycle.
	`MTG_ASSERT_NEXT(a_valid_pulse, valid, !valid, "result strobe longer than one cycle")
	// Any accepted transaction keeps the engine busy next cycle.
	`MTG_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after accept")
	// A seed leaves the engine busy, without a result, once taken.
	`MTG_ASSERT_NEXT(a_seed_long, seed_accept, busy && !valid, "seed ended early or gave a result")

endmodule

bind mt19937_generator_top mtg_checker u_mtg_checker (.*);
`default_nettype wire

FILE: tb/mt19937_generator_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MT19937 generator testbench
// Drives seed and draw transactions into mt19937_generator_top and checks
// every value against a local Mersenne Twister predictor or a known value
// from a short directed table, which covers the bound extremes and the draw
// before any seed. A long run of draws then crosses several regenerations,
// and a mixed run with reseeds follows. The sender pauses at random.
// ----------------------------------------------------------------------------
module mt19937_generator_top_tb;
	import mtg_pkg::*;

	localparam int DIRECTED_ROWS    = 18;
	localparam int RANDOM_ITEMS     = 1700;
	// Draws only up to this point, so the state regenerates several times
	// without a reseed in between.
	localparam int LONG_DRAW_RUN    = 1300;
	localparam int MAX_RANDOM_SEEDS = 40;
	localparam int ITEM_COUNT       = DIRECTED_ROWS + RANDOM_ITEMS;
	// Slowest run: every seed (random, directed, and the implicit default
	// seed) fills the whole state, and every item pays the draw latency plus
	// the longest sender gap. Allow four times that.
	localparam int CYCLE_LIMIT =
		4 * ((MAX_RANDOM_SEEDS + 8) * (STATE_WORDS + 16) + ITEM_COUNT * 16);

	typedef struct packed {
		logic        op;
		logic [31:0] seed;
		logic [31:0] bound;
		logic        known;
		logic [31:0] known_value;
	} stim_row_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic        operation  = OP_DRAW;
	logic [31:0] seed_value = 32'd0;
	logic [31:0] max_number = 32'd0;
	logic        busy;
	logic        valid;
	logic [31:0] value;

	// Predictor state: the twister words, the read position, and whether
	// any seed has been applied yet.
	logic [31:0] twister_state [STATE_WORDS];
	int          draw_index   = STATE_WORDS;
	bit          state_seeded = 1'b0;

	logic [31:0] pending_values [$];
	int          mismatch_count = 0;
	int          cycle_count    = 0;

	// Directed table. The known values come straight from the standard
	// sequence for the default seed, or from a zero bound.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{OP_DRAW, 32'd0,         FULL_RANGE,    1'b1, 32'd3499211612}, // draw before any seed
		'{OP_DRAW, 32'd0,         FULL_RANGE,    1'b1, 32'd581869302},
		'{OP_DRAW, 32'hFFFF_FFFF, 32'd0,         1'b1, 32'd0},
		'{OP_DRAW, 32'd0,         32'd1,         1'b0, 32'd0},
		'{OP_DRAW, 32'd0,         32'h7FFF_FFFF, 1'b0, 32'd0},
		'{OP_DRAW, 32'd0,         32'hFFFF_FFFE, 1'b0, 32'd0},
		'{OP_DRAW, 32'd0,         32'h8000_0000, 1'b0, 32'd0},
		'{OP_SEED, 32'd0,         FULL_RANGE,    1'b0, 32'd0},
		'{OP_DRAW, 32'd0,         FULL_RANGE,    1'b0, 32'd0},
		'{OP_DRAW, 32'd0,         32'd0,         1'b1, 32'd0},
		'{OP_SEED, 32'hFFFF_FFFF, 32'd0,         1'b0, 32'd0},
		'{OP_DRAW, 32'd0,         FULL_RANGE,    1'b0, 32'd0},
		'{OP_SEED, DEFAULT_SEED,  32'h1234_5678, 1'b0, 32'd0},  // bound ignored
		'{OP_DRAW, 32'd0,         FULL_RANGE,    1'b1, 32'd3499211612},
		'{OP_SEED, 32'hAAAA_AAAA, 32'd0,         1'b0, 32'd0},
		'{OP_SEED, 32'h5555_5555, FULL_RANGE,    1'b0, 32'd0},  // seed right after seed
		'{OP_DRAW, 32'd0,         32'd9,         1'b0, 32'd0},
		'{OP_DRAW, 32'd0,         FULL_RANGE,    1'b0, 32'd0}
	};

	mt19937_generator_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.seed_value (seed_value),
		.max_number (max_number),
		.valid      (valid),
		.value      (value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Fill all words from one seed word with the init recurrence and mark
	// the state as used up.
	function automatic void seed_state(input logic [31:0] s);
		logic [31:0] prev;
		twister_state[0] = s;
		for (int i = 1; i < STATE_WORDS; i++) begin
			prev = twister_state[i - 1];
			twister_state[i] = INIT_MULT * (prev ^ (prev >> 30)) + 32'(i);
		end
		draw_index   = STATE_WORDS;
		state_seeded = 1'b1;
	endfunction

	// Regenerate in place, in order: later words see the already updated
	// far and next words, as the standard algorithm requires.
	function automatic void twist_state();
		logic [31:0] mixed;
		int          nx;
		int          fa;
		for (int k = 0; k < STATE_WORDS; k++) begin
			nx    = (k + 1) % STATE_WORDS;
			fa    = (k + SHIFT_M) % STATE_WORDS;
			mixed = (twister_state[k] & TOP_BIT_SEL) | (twister_state[nx] & LOW_BITS_SEL);
			twister_state[k] = twister_state[fa] ^ (mixed >> 1) ^
				(mixed[0] ? MATRIX_A : 32'd0);
		end
		draw_index = 0;
	endfunction

	function automatic logic [31:0] temper_word(input logic [31:0] w);
		logic [31:0] t;
		t = w ^ (w >> 11);
		t = t ^ ((t << 7) & TEMPER_B);
		t = t ^ ((t << 15) & TEMPER_C);
		return t ^ (t >> 18);
	endfunction

	// Advance the predictor by one draw and return the scaled value.
	function automatic logic [31:0] next_draw_value(input logic [31:0] bound);
		logic [31:0] raw;
		logic [63:0] prod;
		if (!state_seeded)
			seed_state(DEFAULT_SEED);
		if (draw_index >= STATE_WORDS)
			twist_state();
		raw        = temper_word(twister_state[draw_index]);
		draw_index = draw_index + 1;
		if (bound == FULL_RANGE)
			return raw;
		prod = {32'd0, raw} * ({32'd0, bound} + 64'd1);
		return prod[63:32];
	endfunction

	// Favor the bound extremes; plain random words make up the rest.
	function automatic logic [31:0] draw_bound();
		case ($urandom_range(0, 7))
			0, 1: return FULL_RANGE;
			2: return 32'd0;
			3: return 32'($urandom_range(1, 15));
			4: return (32'd1 << $urandom_range(0, 31)) - 32'd1;
			5: return FULL_RANGE - 32'($urandom_range(1, 255));
			default: return $urandom;
		endcase
	endfunction

	function automatic int sender_gap();
		return ($urandom_range(0, 99) < 24) ? $urandom_range(1, 6) : 0;
	endfunction

	// Present one transaction and hold it until the block takes it, then
	// record what the block owes us for it. Called just after a rising edge.
	task automatic drive_transaction(input logic op, input logic [31:0] sv,
			input logic [31:0] bound, input logic known, input logic [31:0] known_value);
		logic [31:0] predicted;
		operation  <= op;
		seed_value <= sv;
		max_number <= bound;
		start      <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if (op == OP_SEED) begin
			seed_state(sv);
		end else begin
			predicted = next_draw_value(bound);
			pending_values.push_back(known ? known_value : predicted);
		end
	endtask

	// Drop start for the requested gap and put noise on the idle fields.
	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			start      <= 1'b0;
			operation  <= 1'($urandom_range(0, 1));
			seed_value <= $urandom;
			max_number <= $urandom;
			repeat (cycles) @(posedge clk);
		end
	endtask

	initial begin
		int          seeds_left;
		logic        op;
		logic [31:0] sv;
		logic [31:0] bound;
		seeds_left = MAX_RANDOM_SEEDS;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			drive_transaction(directed_rows[r].op, directed_rows[r].seed,
				directed_rows[r].bound, directed_rows[r].known,
				directed_rows[r].known_value);
			pause_sender(sender_gap());
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			op = OP_DRAW;
			if (n >= LONG_DRAW_RUN && seeds_left > 0 && $urandom_range(0, 15) == 0) begin
				op         = OP_SEED;
				seeds_left = seeds_left - 1;
			end
			sv    = $urandom;
			bound = draw_bound();
			drive_transaction(op, sv, bound, 1'b0, 32'd0);
			// Run back to back through one stretch so no-gap timing is covered.
			pause_sender((n >= 200 && n < 600) ? 0 : sender_gap());
		end
		start <= 1'b0;

		// Drain, then leave room for a trailing seed fill to finish so any
		// stray strobe still gets caught.
		while (pending_values.size() != 0)
			@(posedge clk);
		repeat (STATE_WORDS + 16) @(posedge clk);

		if (mismatch_count == 0 && pending_values.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Compare each strobed value with the oldest pending one.
	always @(posedge clk) begin : check_values
		logic [31:0] wanted;
		if (arst_n && valid === 1'b1) begin
			if (pending_values.size() == 0) begin
				mismatch_count = mismatch_count + 1;
				if (mismatch_count <= 10)
					$display("value %h strobed with no draw pending", value);
			end else begin
				wanted = pending_values.pop_front();
				if (value !== wanted) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= 10)
						$display("value mismatch: expected %h, got %h", wanted, value);
				end
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
`default_nettype wire

FILE: files.f
+incdir+src
src/mtg_pkg.sv
src/mtg_ram.sv
src/mt19937_generator_top.sv
src/mtg_checker.sv
tb/mt19937_generator_top_tb.sv
